[hdl/dzs_pkg.sv]
// ----------------------------------------------------------------------------
// dzs_pkg
// Shared widths, codes, state types and defaults of the disjoint zero-sum
// reach update block.
// ----------------------------------------------------------------------------
package dzs_pkg;

	// Parameter defaults of the top level.
	localparam int GROUP_MAX_D    = 32;
	localparam int WEIGHT_SLOTS_D = 40;
	localparam int FRAME_DEPTH_D  = 38;

	// Field widths.
	localparam int DEPTH_W    = 6;
	localparam int ELEM_W     = 5;
	localparam int STATUS_W   = 2;
	localparam int LEN_W      = 6;
	localparam int MOD_W      = 6;
	localparam int CNT_W      = 3;
	localparam int MAXLEN_W   = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	// Group order never exceeds 32, so six bits always hold it.
	localparam int ORDER_W    = 6;
	localparam int DIGITS_MAX = 5;

	// Legal configuration ranges and reset values.
	localparam int MOD_MIN = 2;
	localparam int MOD_MAX = 32;
	localparam int CNT_MIN = 1;
	localparam int CNT_MAX = 5;
	localparam int LEN_MIN = 1;

	localparam logic [MOD_W-1:0]    MOD_RST = 6'd3;
	localparam logic [CNT_W-1:0]    CNT_RST = 3'd3;
	localparam logic [MAXLEN_W-1:0] LEN_RST = 6'd10;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAXLEN  = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_PRUNED  = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	// Status of the permutation unit toward the sequencer.
	typedef struct packed {
		logic               done;
		logic               ok;
		logic [ORDER_W-1:0] order;
	} perm_stat_t;

	typedef enum logic [1:0] {
		P_IDLE,
		P_POW,
		P_VDIG,
		P_PERM
	} perm_state_t;

	typedef enum logic [3:0] {
		T_IDLE,
		T_WAIT,
		T_SUMS,
		T_ROWA,
		T_ROWB,
		T_ROWW,
		T_ZROW,
		T_REACH,
		T_ZWORD,
		T_SUMW,
		T_DONE
	} top_state_t;

endpackage

[hdl/dzs_ifs.sv]
// ----------------------------------------------------------------------------
// dzs interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface dzs_item_if import dzs_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [DEPTH_W-1:0]  parent_depth;
	logic [ELEM_W-1:0]   element;

	modport source (output valid, output parent_depth, output element, input ready);
	modport sink (input valid, input parent_depth, input element, output ready);
endinterface

interface dzs_result_if import dzs_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [LEN_W-1:0]    min_zero_sum_len;

	modport source (output valid, output status, output min_zero_sum_len, input ready);
	modport sink (input valid, input status, input min_zero_sum_len, output ready);
endinterface

interface dzs_cfg_if import dzs_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/dzs_ram.sv]
// ----------------------------------------------------------------------------
// dzs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dzs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/dzs_perm.sv]
// ----------------------------------------------------------------------------
// dzs_perm
// Works out the group order and the translation by one element: a table of
// s + v for every s, its inverse, and a mask shifter built on the table.
// ----------------------------------------------------------------------------
module dzs_perm import dzs_pkg::*; #(
	parameter int GROUP_MAX = GROUP_MAX_D,
	localparam int IW = $clog2(GROUP_MAX)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [MOD_W-1:0]     modulus,
	input  logic [CNT_W-1:0]     count,
	input  logic [ELEM_W-1:0]    elem,
	input  logic [GROUP_MAX-1:0] mask_in,
	input  logic [IW-1:0]        idx,
	output perm_stat_t           stat,
	output logic [GROUP_MAX-1:0] mask_out,
	output logic [IW-1:0]        inv_out
);

	localparam int PW = MOD_W + ORDER_W;
	localparam int TW = ORDER_W + 1;
	localparam int CW = MOD_W + 1;
	localparam int DW = IW + 1;

	perm_state_t state_q, state_d;

	logic [2:0]                    i_q;
	logic                          bad_q;
	logic                          done_q;
	logic                          ok_q;
	logic [ORDER_W-1:0]            pw_q [8];
	logic [ORDER_W-1:0]            n_q;
	logic [ELEM_W-1:0]             elem_q;
	logic [IW-1:0]                 s_q;
	logic [DIGITS_MAX-1:0][IW-1:0] sd_q;
	logic [DIGITS_MAX-1:0][IW-1:0] vd_q;
	logic [IW-1:0]                 perm_q [GROUP_MAX];
	logic [IW-1:0]                 inv_q [GROUP_MAX];

	logic [PW-1:0]                 prod;
	logic [ORDER_W-1:0]            order_now;
	logic                          elem_ok;
	logic                          s_last;
	logic                          v_hit;
	logic                          range_ok;
	logic [DIGITS_MAX-1:0][IW-1:0] sd_inc;
	logic [TW-1:0]                 tsum;
	logic [GROUP_MAX-1:0]          nmask;

	assign prod      = PW'(pw_q[i_q]) * PW'(modulus);
	assign order_now = pw_q[count];
	assign elem_ok   = (elem_q != '0) && (ORDER_W'(elem_q) < order_now);
	assign s_last    = (ORDER_W'(s_q) + ORDER_W'(1)) == n_q;
	assign v_hit     = ELEM_W'(s_q) == elem_q;

	always_comb begin
		range_ok = (modulus inside {[MOD_MIN:MOD_MAX]}) && (count inside {[CNT_MIN:CNT_MAX]});
	end

	// Mixed-radix increment of the digit vector of s.
	always_comb begin
		logic carry;
		carry  = 1'b1;
		sd_inc = sd_q;
		for (int i = 0; i < DIGITS_MAX; i++) begin
			if ((3'(i) < count) && carry) begin
				if ((CW'(sd_q[i]) + CW'(1)) == CW'(modulus)) begin
					sd_inc[i] = '0;
				end else begin
					sd_inc[i] = sd_q[i] + 1'b1;
					carry     = 1'b0;
				end
			end
		end
	end

	// s + v: plain sum, less one place weight for every digit that wraps.
	always_comb begin
		logic [DW-1:0] dsum;
		tsum = TW'(s_q) + TW'(elem_q);
		for (int i = 0; i < DIGITS_MAX; i++) begin
			dsum = DW'(sd_q[i]) + DW'(vd_q[i]);
			if ((3'(i) < count) && (CW'(dsum) >= CW'(modulus))) begin
				tsum = tsum - TW'(pw_q[i + 1]);
			end
		end
	end

	always_comb begin
		for (int s = 0; s < GROUP_MAX; s++) begin
			nmask[s] = ORDER_W'(s) < n_q;
		end
	end

	always_comb begin
		mask_out = '0;
		for (int s = 0; s < GROUP_MAX; s++) begin
			if (mask_in[s] && nmask[s]) begin
				mask_out[perm_q[s]] = 1'b1;
			end
		end
	end

	assign inv_out = inv_q[idx];
	assign stat    = '{done: done_q, ok: ok_q, order: n_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			P_IDLE: begin
				if (start) state_d = P_POW;
			end
			P_POW: begin
				if (bad_q) begin
					state_d = P_IDLE;
				end else if (i_q == count) begin
					state_d = elem_ok ? P_VDIG : P_IDLE;
				end
			end
			P_VDIG: begin
				if (v_hit) state_d = P_PERM;
			end
			P_PERM: begin
				if (s_last) state_d = P_IDLE;
			end
			default: state_d = P_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q    <= '0;
			bad_q  <= 1'b0;
			done_q <= 1'b0;
			ok_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				P_IDLE: begin
					if (start) begin
						i_q   <= '0;
						bad_q <= !range_ok;
					end
				end
				P_POW: begin
					if (bad_q) begin
						done_q <= 1'b1;
						ok_q   <= 1'b0;
					end else if (i_q == count) begin
						if (!elem_ok) begin
							done_q <= 1'b1;
							ok_q   <= 1'b0;
						end
					end else begin
						if (prod > PW'(GROUP_MAX)) bad_q <= 1'b1;
						i_q <= i_q + 3'd1;
					end
				end
				P_PERM: begin
					if (s_last) begin
						done_q <= 1'b1;
						ok_q   <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			P_IDLE: begin
				if (start) begin
					pw_q[0] <= ORDER_W'(1);
					elem_q  <= elem;
				end
			end
			P_POW: begin
				if (i_q == count) begin
					n_q  <= order_now;
					s_q  <= '0;
					sd_q <= '0;
				end else begin
					pw_q[3'(i_q + 3'd1)] <= prod[ORDER_W-1:0];
				end
			end
			P_VDIG: begin
				if (v_hit) begin
					vd_q <= sd_q;
					s_q  <= '0;
					sd_q <= '0;
				end else begin
					s_q  <= s_q + 1'b1;
					sd_q <= sd_inc;
				end
			end
			P_PERM: begin
				perm_q[s_q]           <= tsum[IW-1:0];
				inv_q[tsum[IW-1:0]]   <= s_q;
				s_q                   <= s_q + 1'b1;
				sd_q                  <= sd_inc;
			end
			default: ;
		endcase
	end

endmodule

[hdl/disjoint_zero_sum_reach_update.sv]
// ----------------------------------------------------------------------------
// disjoint_zero_sum_reach_update
// Extends a stored search frame by one element of C_p^r and stores the child.
// A bad element or setting answers before the s + v table is built; a depth
// or length out of range answers only after the table is built.
// One item is in work at a time; the pair-row memory is read twice per row
// through its single read port.
// Reset restores the register defaults. Frame 0 is held as constants, so no
// memory is cleared after reset.
// ----------------------------------------------------------------------------
module disjoint_zero_sum_reach_update import dzs_pkg::*; #(
	parameter int GROUP_MAX    = GROUP_MAX_D,
	parameter int WEIGHT_SLOTS = WEIGHT_SLOTS_D,
	parameter int FRAME_DEPTH  = FRAME_DEPTH_D
) (
	input logic          clk,
	input logic          arst_n,
	dzs_item_if.sink     item,
	dzs_result_if.source result,
	dzs_cfg_if.sink      cfg
);

	localparam int IW         = $clog2(GROUP_MAX);
	localparam int FW         = $clog2(FRAME_DEPTH + 1);
	localparam int WSTRIDE    = WEIGHT_SLOTS + 1;
	localparam int ROW_DEPTH  = (FRAME_DEPTH + 1) * GROUP_MAX;
	localparam int WORD_DEPTH = (FRAME_DEPTH + 1) * WSTRIDE;
	localparam int RAW        = $clog2(ROW_DEPTH);
	localparam int WAW        = $clog2(WORD_DEPTH);
	localparam int SW         = $clog2(WSTRIDE);
	localparam int LW         = MAXLEN_W + 1;

	// Configuration registers. The port never stalls; the user must write
	// only while the block is idle, which the block itself does not enforce.
	logic [MOD_W-1:0]    mod_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [MAXLEN_W-1:0] len_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MOD_RST;
			cnt_q <= CNT_RST;
			len_q <= LEN_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MODULUS: mod_q <= cfg.data;
				REG_COUNT:   cnt_q <= cfg.data[CNT_W-1:0];
				REG_MAXLEN:  len_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Sequencer state and item registers.
	top_state_t state_q, state_d;

	logic [DEPTH_W-1:0]   pd_q;
	logic [ELEM_W-1:0]    v_q;
	logic [RAW-1:0]       rbase_rd_q, rbase_wr_q;
	logic [WAW-1:0]       wbase_rd_q, wbase_wr_q;
	logic [IW-1:0]        b_q;
	logic [SW-1:0]        w_q;
	logic                 dv_s1;
	logic [SW-1:0]        dw_s1;
	logic [GROUP_MAX-1:0] sums_q, a_q, prev_q;
	logic [LEN_W-1:0]     minz_q;
	status_t              fin_q;
	logic                 out_vld_q;
	status_t              out_status_q;
	logic [LEN_W-1:0]     out_len_q;

	// The permutation unit: group order, s + v table and its inverse. It
	// captures the element straight from the request as it is accepted.
	perm_stat_t           pstat;
	logic                 perm_start;
	logic [GROUP_MAX-1:0] shift_in, shift_out;
	logic [IW-1:0]        inv_b;

	dzs_perm #(.GROUP_MAX(GROUP_MAX)) u_perm (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (perm_start),
		.modulus  (mod_q),
		.count    (cnt_q),
		.elem     (item.element),
		.mask_in  (shift_in),
		.idx      (b_q),
		.stat     (pstat),
		.mask_out (shift_out),
		.inv_out  (inv_b)
	);

	// Pair rows live in one memory, GROUP_MAX rows per frame. The reach words
	// and the sum mask share the other memory: WEIGHT_SLOTS reach words per
	// frame followed by the sum mask.
	logic                 row_we, word_we;
	logic [RAW-1:0]       row_waddr, row_raddr;
	logic [WAW-1:0]       word_waddr, word_raddr;
	logic [GROUP_MAX-1:0] row_wdata, row_rdata, word_wdata, word_rdata;

	dzs_ram #(.WIDTH(GROUP_MAX), .DEPTH(ROW_DEPTH)) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_waddr),
		.wdata (row_wdata),
		.raddr (row_raddr),
		.rdata (row_rdata)
	);

	dzs_ram #(.WIDTH(GROUP_MAX), .DEPTH(WORD_DEPTH)) u_word_ram (
		.clk   (clk),
		.we    (word_we),
		.waddr (word_waddr),
		.wdata (word_wdata),
		.raddr (word_raddr),
		.rdata (word_rdata)
	);

	// Frame 0 is never stored: when it is the parent, its constant contents
	// (all zero, but for the empty-sum bit of reach word 0) replace the
	// memory data.
	logic                 pd_zero;
	logic [GROUP_MAX-1:0] row_eff, word_eff, elem_bit, row_new, reach_new;
	logic                 cfg_ok, last_row, order_short;

	assign pd_zero  = pd_q == '0;
	assign row_eff  = pd_zero ? '0 : row_rdata;
	assign word_eff = pd_zero ? ((dw_s1 == '0) ? GROUP_MAX'(1) : '0) : word_rdata;
	assign elem_bit = GROUP_MAX'(1) << v_q[IW-1:0];

	// The length bound and the depth are checked here; modulus, rank and
	// element are checked by the permutation unit.
	assign cfg_ok = (LW'(len_q) >= LW'(LEN_MIN)) && (LW'(len_q) <= LW'(FRAME_DEPTH))
		&& (LW'(len_q) < LW'(WEIGHT_SLOTS)) && (pd_q < len_q);

	assign last_row    = (ORDER_W'(b_q) + ORDER_W'(1)) == pstat.order;
	assign order_short = (LW'(pstat.order) < LW'(GROUP_MAX));

	// Child row b: the parent row itself, the row that lands on b when the
	// element joins the first subset, the row shifted when it joins the
	// second, and the singleton pairs with every reachable sum b.
	assign row_new   = a_q | row_eff | shift_out | (sums_q[b_q] ? elem_bit : '0);
	assign reach_new = word_eff | shift_out;

	// One shifter serves the pair rows, the reach words and the sum mask.
	always_comb begin
		case (state_q)
			T_ROWW:  shift_in = a_q;
			T_REACH: shift_in = prev_q;
			default: shift_in = sums_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, memory addresses and write strobes.
	always_comb begin
		state_d    = state_q;
		item.ready = 1'b0;
		perm_start = 1'b0;
		row_we     = 1'b0;
		word_we    = 1'b0;
		row_raddr  = rbase_rd_q + RAW'(b_q);
		row_waddr  = rbase_wr_q + RAW'(b_q);
		row_wdata  = row_new;
		word_raddr = wbase_rd_q + WAW'(w_q);
		word_waddr = wbase_wr_q + WAW'(dw_s1);
		word_wdata = reach_new;
		case (state_q)
			T_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					perm_start = 1'b1;
					state_d    = T_WAIT;
				end
			end
			T_WAIT: begin
				if (pstat.done) begin
					state_d = (pstat.ok && cfg_ok) ? T_SUMS : T_DONE;
				end
			end
			T_SUMS: begin
				word_raddr = wbase_rd_q + WAW'(WEIGHT_SLOTS);
				state_d    = T_ROWA;
			end
			T_ROWA: begin
				state_d = T_ROWB;
			end
			T_ROWB: begin
				row_raddr = rbase_rd_q + RAW'(inv_b);
				state_d   = T_ROWW;
			end
			T_ROWW: begin
				// Row 0 decides pruning before anything is stored.
				row_raddr = rbase_rd_q + RAW'(b_q) + RAW'(1);
				if ((b_q == '0) && row_new[0]) begin
					state_d = T_DONE;
				end else begin
					row_we = 1'b1;
					if (!last_row) begin
						state_d = T_ROWB;
					end else if (order_short) begin
						state_d = T_ZROW;
					end else begin
						state_d = T_REACH;
					end
				end
			end
			T_ZROW: begin
				row_we    = 1'b1;
				row_wdata = '0;
				if (b_q == IW'(GROUP_MAX - 1)) state_d = T_REACH;
			end
			T_REACH: begin
				word_we = dv_s1;
				if ((LW'(w_q) > LW'(len_q)) && !dv_s1) state_d = T_ZWORD;
			end
			T_ZWORD: begin
				word_waddr = wbase_wr_q + WAW'(w_q);
				word_wdata = '0;
				if (w_q == SW'(WEIGHT_SLOTS)) begin
					state_d = T_SUMW;
				end else begin
					word_we = 1'b1;
				end
			end
			T_SUMW: begin
				word_we    = 1'b1;
				word_waddr = wbase_wr_q + WAW'(WEIGHT_SLOTS);
				word_wdata = sums_q | elem_bit | shift_out;
				state_d    = T_DONE;
			end
			T_DONE: begin
				if (!out_vld_q || result.ready) state_d = T_IDLE;
			end
			default: state_d = T_IDLE;
		endcase
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			T_IDLE: begin
				if (item.valid) begin
					pd_q <= item.parent_depth;
					v_q  <= item.element;
				end
			end
			T_WAIT: begin
				rbase_rd_q <= RAW'(FW'(pd_q)) * RAW'(GROUP_MAX);
				rbase_wr_q <= (RAW'(FW'(pd_q)) + RAW'(1)) * RAW'(GROUP_MAX);
				wbase_rd_q <= WAW'(FW'(pd_q)) * WAW'(WSTRIDE);
				wbase_wr_q <= (WAW'(FW'(pd_q)) + WAW'(1)) * WAW'(WSTRIDE);
				b_q        <= '0;
				fin_q      <= ST_INVALID;
				minz_q     <= '0;
			end
			T_ROWA: begin
				sums_q <= pd_zero ? '0 : word_rdata;
			end
			T_ROWB: begin
				a_q <= row_eff;
			end
			T_ROWW: begin
				a_q    <= '0;
				b_q    <= b_q + 1'b1;
				w_q    <= '0;
				dv_s1  <= 1'b0;
				dw_s1  <= '0;
				prev_q <= '0;
				if ((b_q == '0) && row_new[0]) fin_q <= ST_PRUNED;
			end
			T_ZROW: begin
				b_q <= b_q + 1'b1;
			end
			T_REACH: begin
				// Reads run one word ahead of the writes; the previous word is
				// kept for the shift into the next size.
				if (LW'(w_q) <= LW'(len_q)) begin
					w_q   <= w_q + 1'b1;
					dw_s1 <= w_q;
					dv_s1 <= 1'b1;
				end else begin
					dv_s1 <= 1'b0;
				end
				if (dv_s1) begin
					prev_q <= word_eff;
					if ((dw_s1 != '0) && reach_new[0] && (minz_q == '0)) begin
						minz_q <= LEN_W'(dw_s1);
					end
				end
			end
			T_ZWORD: begin
				if (w_q != SW'(WEIGHT_SLOTS)) w_q <= w_q + 1'b1;
			end
			T_SUMW: begin
				fin_q <= ST_OK;
			end
			default: ;
		endcase
	end

	// Output register: a result waits here while the next item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if ((state_q == T_DONE) && (!out_vld_q || result.ready)) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == T_DONE) && (!out_vld_q || result.ready)) begin
			out_status_q <= fin_q;
			out_len_q    <= (fin_q == ST_OK) ? minz_q : '0;
		end
	end

	assign result.valid            = out_vld_q;
	assign result.status           = out_status_q;
	assign result.min_zero_sum_len = out_len_q;

	// Frame 0 is constant and must never be written.
	a_row_frame0: assert property (@(posedge clk) disable iff (!arst_n)
		row_we |-> (row_waddr >= RAW'(GROUP_MAX)))
		else $error("pair-row write into frame 0");

	a_word_frame0: assert property (@(posedge clk) disable iff (!arst_n)
		word_we |-> (word_waddr >= WAW'(WSTRIDE)))
		else $error("reach word write into frame 0");

	// The permutation unit finishes only while the sequencer waits for it.
	a_perm_done: assert property (@(posedge clk) disable iff (!arst_n)
		pstat.done |-> (state_q == T_WAIT))
		else $error("permutation unit finished outside the wait state");

	// Pruned and invalid results never carry a length.
	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && (out_status_q != ST_OK)) |-> (out_len_q == '0))
		else $error("length reported with a non-ok status");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the disjoint zero-sum reach update block. A local
// copy of the frame tables predicts every result. Items are sent through
// the valid/ready channels under several idle and stall phases and several
// group settings.
// ----------------------------------------------------------------------------
module tb_top;
	import dzs_pkg::*;

	localparam int NFRAMES    = FRAME_DEPTH_D + 1;
	localparam int CYCLE_CAP  = 1000000;
	localparam int DRAIN_WAIT = 300;

	// An index that names no register; a write to it changes nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		status_t          status;
		logic [LEN_W-1:0] len;
	} zs_result_t;

	logic clk;
	logic arst_n;

	dzs_item_if   item_ch ();
	dzs_result_if res_ch ();
	dzs_cfg_if    cfg_ch ();

	disjoint_zero_sum_reach_update DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// Local copy of the registers and of the stored frames.
	int unsigned mdl_mod;
	int unsigned mdl_cnt;
	int unsigned mdl_maxlen;
	logic [31:0] mdl_sums  [NFRAMES];
	logic [31:0] mdl_rows  [NFRAMES][GROUP_MAX_D];
	logic [31:0] mdl_reach [NFRAMES][WEIGHT_SLOTS_D];
	bit          frame_written [NFRAMES];

	zs_result_t pending_results[$];
	int         fail_count;
	int         cycle_count;

	// Idle control: percent of cycles the sender waits and the receiver stalls.
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_req;
	bit holding;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit. Reaching it means something hung.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Predictor of the group arithmetic and the frame update.
	// ------------------------------------------------------------------------
	function automatic int unsigned group_order();
		int unsigned ord;
		ord = 1;
		if (mdl_mod < 2 || mdl_mod > 32) return 0;
		if (mdl_cnt < 1 || mdl_cnt > 5) return 0;
		if (mdl_maxlen < 1 || mdl_maxlen > FRAME_DEPTH_D || mdl_maxlen >= WEIGHT_SLOTS_D)
			return 0;
		for (int i = 0; i < mdl_cnt; i++) begin
			ord = ord * mdl_mod;
			if (ord > GROUP_MAX_D) return 0;
		end
		return ord;
	endfunction

	function automatic int unsigned group_add(int unsigned a, int unsigned b);
		int unsigned acc;
		int unsigned mul;
		acc = 0;
		mul = 1;
		for (int i = 0; i < mdl_cnt; i++) begin
			acc += (((a % mdl_mod) + (b % mdl_mod)) % mdl_mod) * mul;
			mul *= mdl_mod;
			a /= mdl_mod;
			b /= mdl_mod;
		end
		return acc;
	endfunction

	// Translates every set bit below the group order by the element.
	function automatic logic [31:0] translate_mask(logic [31:0] m, int unsigned v,
			int unsigned ord);
		logic [31:0] r;
		r = '0;
		for (int s = 0; s < ord; s++)
			if (m[s]) r[group_add(s, v)] = 1'b1;
		return r;
	endfunction

	// True when an item would make the block read a stored frame.
	function automatic bit reads_frame(int unsigned pd, int unsigned v);
		int unsigned ord;
		ord = group_order();
		return ord != 0 && pd < mdl_maxlen && v != 0 && v < ord;
	endfunction

	function automatic zs_result_t extend_frame(int unsigned pd, int unsigned v);
		int unsigned ord;
		logic [31:0] sums;
		logic [31:0] rows [GROUP_MAX_D];
		logic [31:0] reach [WEIGHT_SLOTS_D];
		zs_result_t  res;
		ord = group_order();
		res.status = ST_INVALID;
		res.len = '0;
		if (!reads_frame(pd, v)) return res;
		sums = mdl_sums[pd];
		for (int a = 0; a < GROUP_MAX_D; a++)
			rows[a] = (a < ord) ? mdl_rows[pd][a] : '0;
		for (int a = 0; a < ord; a++) begin
			if (mdl_rows[pd][a] != '0) begin
				rows[group_add(a, v)] |= mdl_rows[pd][a];
				rows[a] |= translate_mask(mdl_rows[pd][a], v, ord);
			end
		end
		for (int a = 0; a < ord; a++)
			if (sums[a]) rows[a][v] = 1'b1;
		if (rows[0][0]) begin
			res.status = ST_PRUNED;
			return res;
		end
		for (int w = 0; w < WEIGHT_SLOTS_D; w++)
			reach[w] = (w <= mdl_maxlen) ? mdl_reach[pd][w] : '0;
		for (int w = int'(mdl_maxlen) - 1; w >= 0; w--)
			if (mdl_reach[pd][w] != '0)
				reach[w + 1] |= translate_mask(mdl_reach[pd][w], v, ord);
		mdl_sums[pd + 1] = sums | (32'd1 << v) | translate_mask(sums, v, ord);
		mdl_rows[pd + 1] = rows;
		mdl_reach[pd + 1] = reach;
		frame_written[pd + 1] = 1'b1;
		res.status = ST_OK;
		for (int w = 1; w <= mdl_maxlen; w++) begin
			if (reach[w][0]) begin
				res.len = w[LEN_W-1:0];
				break;
			end
		end
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Driving and checking.
	// ------------------------------------------------------------------------
	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// Sends one request and records its expected result once accepted. An
	// item that would read a never written frame is redirected to frame 0.
	task automatic send_item(int unsigned pd, int unsigned v);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			item_ch.valid = 1'b0;
		end
		if (reads_frame(pd, v) && !frame_written[pd]) pd = 0;
		@(negedge clk);
		item_ch.valid = 1'b1;
		item_ch.parent_depth = pd[DEPTH_W-1:0];
		item_ch.element = v[ELEM_W-1:0];
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		pending_results.push_back(extend_frame(pd, v));
	endtask

	task automatic drop_valid();
		@(negedge clk);
		item_ch.valid = 1'b0;
	endtask

	// Waits until all results are in and the block has gone quiet.
	task automatic drain();
		drop_valid();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = val[CFG_DATA_W-1:0];
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			REG_MODULUS: mdl_mod = val & 6'h3F;
			REG_COUNT:   mdl_cnt = val & 3'h7;
			REG_MAXLEN:  mdl_maxlen = val & 6'h3F;
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic set_group(int unsigned p, int unsigned r, int unsigned len);
		drain();
		write_reg(REG_MODULUS, p);
		write_reg(REG_COUNT, r);
		write_reg(REG_MAXLEN, len);
	endtask

	// Result checker: each accepted result against the oldest expectation.
	always @(posedge clk) begin
		zs_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("mismatch at %0t: result with nothing expected", $realtime);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (res_ch.status !== want.status)
					report_mismatch("status", res_ch.status, want.status);
				if (res_ch.min_zero_sum_len !== want.len)
					report_mismatch("min_zero_sum_len", res_ch.min_zero_sum_len, want.len);
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off on request.
	always @(negedge clk) begin
		res_ch.ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		holding = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				holding = 1'b1;
				repeat (400) @(negedge clk);
				holding = 1'b0;
				hold_req = 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus.
	// ------------------------------------------------------------------------

	// Mostly a walk along written frames with legal elements; the rest is fully
	// random items, identity, out-of-range elements and depths at or past max_length.
	task automatic random_item();
		int unsigned ord;
		int unsigned pd;
		int unsigned v;
		int unsigned pick;
		ord = group_order();
		pick = $urandom_range(99);
		if (ord == 0 || pick < 10) begin
			pd = $urandom_range(63);
			v = $urandom_range(31);
		end else if (pick < 15) begin
			pd = $urandom_range(63, mdl_maxlen);
			v = $urandom_range(31);
		end else if (pick < 20) begin
			pd = $urandom_range(mdl_maxlen - 1);
			v = ($urandom_range(1) != 0) ? 0 : $urandom_range(31, ord);
		end else begin
			// Prefer the deepest written frame to grow long chains.
			pd = 0;
			for (int f = 0; f < mdl_maxlen; f++)
				if (frame_written[f]) pd = f;
			if ($urandom_range(3) == 0) pd = $urandom_range(pd);
			v = $urandom_range(ord - 1, 1);
		end
		send_item(pd, v);
	endtask

	task automatic run_random(int count);
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				case ((i / 40) % 4)
					0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
					1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
					2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
					default: begin send_idle_pct = 25; recv_stall_pct = 25; end
				endcase
			end
			random_item();
		end
	endtask

	// Directed items under the reset settings, C_3^3 with max_length 10.
	task automatic test_directed();
		send_item(0, 1);
		send_item(0, 26);
		send_item(0, 0);
		send_item(0, 27);
		send_item(0, 31);
		send_item(10, 1);
		send_item(63, 5);
		send_item(9, 0);
		// A chain that reaches a zero-sum of length two, then a second one.
		send_item(0, 1);
		send_item(1, 2);
		send_item(2, 1);
		send_item(2, 2);
		send_item(2, 13);
		send_item(3, 13);
		send_item(1, 1);
		send_item(2, 1);
		send_item(3, 1);
		drain();
	endtask

	// Legal extremes of the configuration and several unusable settings.
	task automatic test_configs();
		set_group(2, 5, 38);
		run_random(60);
		set_group(32, 1, 1);
		send_item(0, 31);
		send_item(0, 16);
		send_item(1, 3);
		run_random(30);
		set_group(2, 1, 5);
		send_item(0, 1);
		send_item(1, 1);
		send_item(2, 1);
		run_random(20);
		// Each unusable setting answers invalid without touching frames.
		set_group(1, 3, 10);
		run_random(5);
		set_group(33, 1, 10);
		run_random(5);
		set_group(63, 7, 63);
		run_random(5);
		set_group(3, 0, 10);
		run_random(5);
		set_group(3, 4, 10);
		run_random(5);
		set_group(2, 5, 0);
		run_random(5);
		set_group(2, 5, 39);
		run_random(5);
		drain();
		write_reg(REG_SPARE, 6'h2A);
	endtask

	// Long receiver hold-off while the sender keeps offering items.
	task automatic test_backpressure();
		set_group(3, 3, 10);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b1;
		for (int i = 0; i < 20; i++) random_item();
	endtask

	task automatic test_random();
		set_group(2, 4, 20);
		run_random(160);
		set_group(5, 2, 38);
		run_random(160);
		set_group(3, 3, 38);
		run_random(120);
		set_group(2, 5, 12);
		run_random(80);
	endtask

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.parent_depth = '0;
		item_ch.element = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		res_ch.ready = 1'b0;
		hold_req = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fail_count = 0;
		cycle_count = 0;
		mdl_mod = MOD_RST;
		mdl_cnt = CNT_RST;
		mdl_maxlen = LEN_RST;
		for (int f = 0; f < NFRAMES; f++) begin
			mdl_sums[f] = '0;
			frame_written[f] = 1'b0;
			for (int a = 0; a < GROUP_MAX_D; a++) mdl_rows[f][a] = '0;
			for (int w = 0; w < WEIGHT_SLOTS_D; w++) mdl_reach[f][w] = '0;
		end
		mdl_reach[0][0] = 32'd1;
		frame_written[0] = 1'b1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_configs();
		test_backpressure();
		test_random();
		drain();

		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
